FILE: hw/rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list unit: command and
// status codes, sequencer states and the fixed payload field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  // Default number of list entries
  localparam int PAL_CAPACITY = 128;

  // Fixed payload field widths
  localparam int CMD_W = 2;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int IDX_W = 7;
  localparam int LEN_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOCATE = 2'd2
  } pal_cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_NOTFOUND = 2'd2
  } pal_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } pal_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pal_in_if.sv
// ----------------------------------------------------------------------------
// pal_in_if
// Request channel: command, 1-based position and value, with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pal_in_if import pal_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/pal_out_if.sv
// ----------------------------------------------------------------------------
// pal_out_if
// Result channel: status, removed value, found index and new list length.
// ----------------------------------------------------------------------------
`default_nettype none

interface pal_out_if import pal_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [STS_W-1:0]        status;
  logic signed [VAL_W-1:0] removed_value;
  logic [IDX_W-1:0]        found_index;
  logic [LEN_W-1:0]        list_length;

  modport source (output valid, status, removed_value, found_index, list_length,
                  input ready);
  modport sink   (input valid, status, removed_value, found_index, list_length,
                  output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/pal_store.sv
// ----------------------------------------------------------------------------
// pal_store
// Entry memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_store import pal_pkg::*; #(
  parameter int CAPACITY = PAL_CAPACITY,
  localparam int ADDR_W  = $clog2(CAPACITY)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [VAL_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [VAL_W-1:0]  rd_data
);

  logic [VAL_W-1:0] mem [CAPACITY];

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pal_seq.sv
// ----------------------------------------------------------------------------
// pal_seq
// Sequencer for the list: streams entry reads through the memory, shifts
// entries up or down by writing each read beat back one place over, scans
// for a match, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_seq import pal_pkg::*; #(
  parameter int CAPACITY = PAL_CAPACITY,
  localparam int ADDR_W  = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  pal_in_if.sink                 req,
  pal_out_if.source              rsp,
  output      logic              wr_en,
  output      logic [ADDR_W-1:0] wr_addr,
  output      logic [VAL_W-1:0]  wr_data,
  output      logic              rd_en,
  output      logic [ADDR_W-1:0] rd_addr,
  input  wire logic [VAL_W-1:0]  rd_data
);

  // Compare width that holds both the position and the count plus one
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  pal_state_t state, state_next;

  logic [CMD_W-1:0]  cmd;
  logic              ok;
  logic [ADDR_W-1:0] pidx;
  logic [VAL_W-1:0]  val;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  rd_cnt;
  logic              dv;
  logic [ADDR_W-1:0] da;
  logic              found;
  logic [ADDR_W-1:0] fidx;
  logic [VAL_W-1:0]  removed;

  logic              out_valid;
  logic [STS_W-1:0]  out_status;
  logic [VAL_W-1:0]  out_removed;
  logic [IDX_W-1:0]  out_index;
  logic [LEN_W-1:0]  out_length;

  logic              accept;
  logic              out_free;
  logic              scan_done;
  logic [CMP_W-1:0]  posx;
  logic [CMP_W-1:0]  cntx;
  logic              ok_ins;
  logic              ok_del;
  logic [CNT_W-1:0]  count_next;
  logic [STS_W-1:0]  status_next;
  logic [VAL_W-1:0]  removed_next;
  logic [IDX_W-1:0]  index_next;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign posx     = CMP_W'(req.position);
  assign cntx     = CMP_W'(count);
  assign ok_ins   = (req.position != '0) && (posx <= cntx + CMP_W'(1)) &&
                    (cntx < CMP_W'(CAPACITY));
  assign ok_del   = (req.position != '0) && (posx <= cntx);

  // Stop the scan once no reads remain (or a match is found) and the last beat has been used
  assign scan_done = (rd_cnt == '0 || found) && !dv;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (scan_done) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and memory ports
  always_comb begin
    req.ready = (state == S_IDLE);
    rd_en     = (state == S_SCAN) && (rd_cnt != '0) && !found;
    rd_addr   = rd_ptr;
    wr_en     = 1'b0;
    wr_addr   = pidx;
    wr_data   = val;
    case (state)
      S_SCAN: begin
        if (dv) begin
          case (cmd)
            CMD_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = da + ADDR_W'(1);
              wr_data = rd_data;
            end
            CMD_DELETE: begin
              wr_en   = (da != pidx);
              wr_addr = da - ADDR_W'(1);
              wr_data = rd_data;
            end
            default: wr_en = 1'b0;
          endcase
        end
      end
      S_FINISH: wr_en = (cmd == CMD_INSERT) && ok;
      default:  wr_en = 1'b0;
    endcase
  end

  // Result fields
  always_comb begin
    count_next   = count;
    status_next  = ST_BAD;
    removed_next = '0;
    index_next   = '0;
    case (cmd)
      CMD_INSERT: begin
        if (ok) begin
          count_next  = count + CNT_W'(1);
          status_next = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (ok) begin
          count_next   = count - CNT_W'(1);
          status_next  = ST_OK;
          removed_next = removed;
        end
      end
      CMD_LOCATE: begin
        if (found) begin
          status_next = ST_OK;
          index_next  = IDX_W'(fidx);
        end else begin
          status_next = ST_NOTFOUND;
        end
      end
      default: status_next = ST_BAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dv        <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= rd_en;
      if (accept) begin
        found <= 1'b0;
      end else if (state == S_SCAN && dv && cmd == CMD_LOCATE && !found &&
                   rd_data == val) begin
        found <= 1'b1;
      end
      if (state == S_FINISH && out_free) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and scan registers
  always_ff @(posedge clk) begin
    da <= rd_ptr;
    if (accept) begin
      cmd  <= req.command;
      val  <= req.item_value;
      pidx <= ADDR_W'(posx - CMP_W'(1));
      case (req.command)
        CMD_INSERT: begin
          ok     <= ok_ins;
          rd_ptr <= ADDR_W'(cntx - CMP_W'(1));
          rd_cnt <= ok_ins ? CNT_W'(cntx - posx + CMP_W'(1)) : '0;
        end
        CMD_DELETE: begin
          ok     <= ok_del;
          rd_ptr <= ADDR_W'(posx - CMP_W'(1));
          rd_cnt <= ok_del ? CNT_W'(cntx - posx + CMP_W'(1)) : '0;
        end
        CMD_LOCATE: begin
          ok     <= 1'b1;
          rd_ptr <= '0;
          rd_cnt <= count;
        end
        default: begin
          ok     <= 1'b0;
          rd_ptr <= '0;
          rd_cnt <= '0;
        end
      endcase
    end else if (rd_en) begin
      // Advance the read pointer: down for insert, up otherwise
      rd_ptr <= (cmd == CMD_INSERT) ? rd_ptr - ADDR_W'(1) : rd_ptr + ADDR_W'(1);
      rd_cnt <= rd_cnt - CNT_W'(1);
    end
    // Hold the entry that delete takes out
    if (state == S_SCAN && dv && cmd == CMD_DELETE && da == pidx) begin
      removed <= rd_data;
    end
    if (state == S_SCAN && dv && cmd == CMD_LOCATE && !found && rd_data == val) begin
      fidx <= da;
    end
    if (state == S_FINISH && out_free) begin
      out_status  <= status_next;
      out_removed <= removed_next;
      out_index   <= index_next;
      out_length  <= LEN_W'(count_next);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.removed_value = out_removed;
  assign rsp.found_index   = out_index;
  assign rsp.list_length   = out_length;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_array_list_unit.sv
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of signed 32-bit values with insert, delete and locate.
//
// Usage: a request beat on req carries a command (insert, delete, locate),
// a 1-based position and a value. Each request gives exactly one result beat
// on rsp with status, removed value, found index and the new list length.
// Requests are taken one at a time; req.ready is high only while the unit
// is idle. The entries live in a single memory with one read and one write
// port; each valid insert or delete and each locate streams reads through
// it, one entry per cycle, and insert and delete write each read entry back
// one place over. The number of entries read is length - position + 1 for
// insert and delete, and for locate up to the first match plus one, or the
// whole length. A new request is taken in the cycle after the result is
// loaded. The result sits in an output register; if rsp is stalled the unit
// still takes the next request and waits only when that one's result is
// ready. Reset empties the list and drops any pending result; the memory
// itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_unit import pal_pkg::*; #(
  parameter int CAPACITY = PAL_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  pal_in_if.sink    req,
  pal_out_if.source rsp
);

  localparam int ADDR_W = $clog2(CAPACITY);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;

  // Entry memory
  pal_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Command sequencer and result register
  pal_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/pal_checker.sv
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks for the list unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_checker import pal_pkg::*; #(
  parameter int CAPACITY = PAL_CAPACITY
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic [STS_W-1:0] status,
  input wire logic [VAL_W-1:0] removed_value,
  input wire logic [IDX_W-1:0] found_index,
  input wire logic [LEN_W-1:0] list_length
);

  // Reset drops any pending result beat
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A stalled result beat holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(removed_value) && $stable(found_index) && $stable(list_length))
    else $error("stalled result changed");

  // One request at a time: ready drops after a request beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Failed commands report no removed value and no index
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> removed_value == '0 && found_index == '0)
    else $error("failed command carries data");

  // Length never exceeds the capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 255) || (int'(list_length) <= CAPACITY))
    else $error("list length above capacity");

endmodule

bind positional_array_list_unit pal_checker #(.CAPACITY(CAPACITY)) u_pal_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .removed_value (rsp.removed_value),
  .found_index   (rsp.found_index),
  .list_length   (rsp.list_length)
);

`default_nettype wire

FILE: sim/tb_positional_array_list_unit.sv
// ----------------------------------------------------------------------------
// tb_positional_array_list_unit
// Self-checking bench for the positional array list unit. A mirror list in
// the bench predicts status, removed value, found index and new length for
// every accepted request beat. The checker compares each result beat with the
// oldest prediction. Traffic covers directed edge cases, a fill to capacity
// followed by a drain, and random insert/delete/locate phases with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module tb_positional_array_list_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int CAPACITY    = PAL_CAPACITY;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_LIMIT = 50;

  // Command code outside the decoded set; the unit answers it as refused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [STS_W-1:0]        status;
    logic signed [VAL_W-1:0] removed_value;
    logic [IDX_W-1:0]        found_index;
    logic [LEN_W-1:0]        list_length;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  pal_in_if  req_bus ();
  pal_out_if rsp_bus ();

  positional_array_list_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Mirror of the list contents and the predicted results still in flight
  logic signed [VAL_W-1:0] list_mirror[$];
  list_result_t            pending_list_results[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int rsp_stall_left = 0;
  bit idle_off       = 1'b0;

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // Value mix: small pool for duplicates, full random, extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 8) - 4;
    if (r < 7) return $urandom();
    if (r == 7) return VAL_MIN;
    if (r == 8) return VAL_MAX;
    return ($urandom_range(0, 1) != 0) ? -1 : 0;
  endfunction

  // Apply one command to the mirror list and return its result
  function automatic list_result_t apply_list_op(input logic [CMD_W-1:0] cmd,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int count;
    int p;
    int k;
    bit hit;
    count = list_mirror.size();
    p = int'(pos);
    hit = 1'b0;
    res.status        = ST_BAD;
    res.removed_value = '0;
    res.found_index   = '0;
    case (cmd)
      CMD_INSERT: begin
        if (p >= 1 && p <= count + 1 && count < CAPACITY) begin
          list_mirror.insert(p - 1, val);
          res.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= count) begin
          res.removed_value = list_mirror[p - 1];
          list_mirror.delete(p - 1);
          res.status = ST_OK;
        end
      end
      CMD_LOCATE: begin
        res.status = ST_NOTFOUND;
        for (k = 0; k < count; k++) begin
          if (!hit && list_mirror[k] == val) begin
            hit = 1'b1;
            res.status = ST_OK;
            res.found_index = k[IDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
    res.list_length = LEN_W'(list_mirror.size());
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("%0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Drive one request beat and record its predicted result once taken
  task automatic send_list_op(input logic [CMD_W-1:0] cmd,
                              input logic [POS_W-1:0] pos,
                              input logic signed [VAL_W-1:0] val);
    int gap;
    bit taken;
    gap = pick_gap();
    taken = 1'b0;
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.command    <= cmd;
    req_bus.position   <= pos;
    req_bus.item_value <= val;
    while (!taken) begin
      @(negedge clk);
      taken = (req_bus.ready === 1'b1);
      @(posedge clk);
    end
    pending_list_results.push_back(apply_list_op(cmd, pos, val));
  endtask

  // Result side stalls: hold ready low for a random count, then one beat high
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (rsp_stall_left != 0) begin
      rsp_bus.ready <= 1'b0;
      rsp_stall_left = rsp_stall_left - 1;
    end else begin
      rsp_bus.ready <= 1'b1;
      rsp_stall_left = pick_gap();
    end
  end

  // Compare each result beat with the oldest prediction
  always @(negedge clk) begin : rsp_check
    list_result_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_list_results.size() == 0) begin
        report_mismatch("result beat with no request pending");
      end else begin
        want = pending_list_results.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch($sformatf("status: got %0d, want %0d",
                                    rsp_bus.status, want.status));
        if (rsp_bus.removed_value !== want.removed_value)
          report_mismatch($sformatf("removed_value: got %0d, want %0d",
                                    rsp_bus.removed_value, want.removed_value));
        if (rsp_bus.found_index !== want.found_index)
          report_mismatch($sformatf("found_index: got %0d, want %0d",
                                    rsp_bus.found_index, want.found_index));
        if (rsp_bus.list_length !== want.list_length)
          report_mismatch($sformatf("list_length: got %0d, want %0d",
                                    rsp_bus.list_length, want.list_length));
      end
    end
  end

  // Refusals and misses on an empty list, plus the unused command
  task automatic test_empty_list();
    send_list_op(CMD_DELETE, 8'd1, 32'sd0);
    send_list_op(CMD_DELETE, 8'd0, 32'sd0);
    send_list_op(CMD_LOCATE, 8'd0, 32'sd0);
    send_list_op(CMD_INSERT, 8'd0, 32'sd7);
    send_list_op(CMD_INSERT, 8'd2, 32'sd7);
    send_list_op(CMD_UNUSED, 8'd1, 32'sd9);
  endtask

  // Value extremes, insert/delete at both ends and the middle, first match
  task automatic test_directed_edges();
    send_list_op(CMD_INSERT, 8'd1, VAL_MIN);
    send_list_op(CMD_INSERT, 8'd2, VAL_MAX);
    send_list_op(CMD_INSERT, 8'd1, 32'sd0);
    send_list_op(CMD_INSERT, 8'd4, -32'sd1);
    send_list_op(CMD_INSERT, 8'd3, 32'sd5);
    send_list_op(CMD_INSERT, 8'd6, 32'sd5);
    send_list_op(CMD_LOCATE, 8'd0, 32'sd5);
    send_list_op(CMD_LOCATE, 8'd0, VAL_MAX);
    send_list_op(CMD_LOCATE, 8'd0, VAL_MIN);
    send_list_op(CMD_LOCATE, 8'd0, 32'sd12345);
    send_list_op(CMD_INSERT, 8'd8, 32'sd3);
    send_list_op(CMD_INSERT, 8'd128, 32'sd3);
    send_list_op(CMD_DELETE, 8'd7, 32'sd0);
    send_list_op(CMD_DELETE, 8'd6, 32'sd0);
    send_list_op(CMD_DELETE, 8'd1, 32'sd0);
    send_list_op(CMD_DELETE, 8'd2, 32'sd0);
    send_list_op(CMD_UNUSED, 8'd128, -32'sd1);
    send_list_op(CMD_LOCATE, 8'd255, -32'sd1);
    send_list_op(CMD_LOCATE, 8'd0, VAL_MIN);
  endtask

  // Fill to capacity, refuse inserts while full, then drain
  task automatic test_fill_and_drain();
    int n;
    n = 0;
    while (list_mirror.size() < CAPACITY)
      send_list_op(CMD_INSERT, POS_W'($urandom_range(1, list_mirror.size() + 1)),
                   pick_value());
    send_list_op(CMD_INSERT, 8'd128, 32'sd1);
    send_list_op(CMD_INSERT, 8'd1, VAL_MAX);
    send_list_op(CMD_LOCATE, 8'd0, list_mirror[CAPACITY-1]);
    send_list_op(CMD_LOCATE, 8'd0, list_mirror[0]);
    send_list_op(CMD_LOCATE, 8'd0, $urandom());
    send_list_op(CMD_DELETE, 8'd128, 32'sd0);
    send_list_op(CMD_INSERT, 8'd128, 32'sh1234_5678);
    send_list_op(CMD_LOCATE, 8'd0, 32'sh1234_5678);
    while (list_mirror.size() > 0) begin
      send_list_op(CMD_DELETE, POS_W'($urandom_range(1, list_mirror.size())), $urandom());
      n++;
      if (n % 8 == 0 && list_mirror.size() > 0)
        send_list_op(CMD_LOCATE, 8'd0,
                     list_mirror[$urandom_range(0, list_mirror.size() - 1)]);
    end
  endtask

  // Random phases alternating growth and shrink, with some noise beats
  task automatic test_random_traffic(input int phases, input int per_phase);
    int phase;
    int n;
    int r;
    int len;
    int ins_top;
    logic [POS_W-1:0] pos;
    for (phase = 0; phase < phases; phase++) begin
      idle_off = (phase % 3 == 2);
      ins_top = (phase % 2 == 0) ? 51 : 31;
      for (n = 0; n < per_phase; n++) begin
        len = list_mirror.size();
        r = $urandom_range(0, 99);
        if (r < 6) begin
          case ($urandom_range(0, 3))
            0: send_list_op(CMD_UNUSED, POS_W'($urandom_range(0, 128)), $urandom());
            1: begin
              pos = (len + 2 <= 128) ? POS_W'($urandom_range(len + 2, 128)) : 8'd0;
              send_list_op(CMD_INSERT, pos, pick_value());
            end
            2: begin
              pos = (len < 128) ? POS_W'($urandom_range(len + 1, 128)) : 8'd0;
              send_list_op(CMD_DELETE, pos, $urandom());
            end
            default: send_list_op(($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_DELETE,
                                  8'd0, pick_value());
          endcase
        end else if (r < ins_top) begin
          send_list_op(CMD_INSERT, POS_W'($urandom_range(1, len + 1)), pick_value());
        end else if (r < 75) begin
          send_list_op(CMD_DELETE, (len > 0) ? POS_W'($urandom_range(1, len)) : 8'd1,
                       $urandom());
        end else if (len > 0 && $urandom_range(0, 9) < 6) begin
          send_list_op(CMD_LOCATE, POS_W'($urandom_range(0, 128)),
                       list_mirror[$urandom_range(0, len - 1)]);
        end else begin
          send_list_op(CMD_LOCATE, POS_W'($urandom_range(0, 128)), pick_value());
        end
      end
    end
    idle_off = 1'b0;
  endtask

  initial begin
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.command    = CMD_INSERT;
    req_bus.position   = '0;
    req_bus.item_value = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_directed_edges();
    test_fill_and_drain();
    test_random_traffic(8, 100);

    // Drain: wait for every result, then allow one full item of latency
    req_bus.valid <= 1'b0;
    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
